@@ hdl/pip_pkg.sv @@
// shared types and constants for the point-in-polygon crossing test
package pip_pkg;

  // width of every coordinate port
  localparam int IN_W = 32;

  // per-edge flags handed from the edge unit to the parity stage
  typedef struct packed {
    logic horiz;    // edge has zero height
    logic h_hit;    // horizontal edge counts for this query
    logic in_band;  // query y inside the half-open band of the edge
    logic neg_a;    // sign of dxe*dyq*sign(dye)
    logic neg_b;    // sign of dxq*|dye|
  } edge_flags_t;

endpackage

@@ hdl/point_in_polygon_crossing.sv @@
// top level: streaming even-odd ray-casting point-in-polygon test
//
// Input channel (in_valid/in_ready): one polygon vertex per word, in order,
// each word carrying the query point and a last-vertex mark. Only the low
// COORD_BITS bits of each coordinate are used, taken as signed.
// Result channel (out_valid/out_ready): one word per polygon, sent after
// its last vertex: out_inside_res is 1 when the crossing count is odd.
// Throughput: one vertex per cycle, sustained, as long as results drain.
// Latency: three register stages; the last vertex of a polygon passes
// stage 1, stage 2 and the output register. The parity register closes
// the only loop, so the rate is set by one XOR plus the product compare.
// A waiting result holds in the output register; vertices keep entering
// until stage 2 holds a last vertex and stage 1 is full; then in_ready drops.
// Reset (synchronous, rst_n low) empties the pipeline, drops any pending
// result and starts a fresh polygon with zero parity.
module point_in_polygon_crossing #(
  parameter int COORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pip_pkg::IN_W-1:0]   in_vertex_x,
  input  logic signed [pip_pkg::IN_W-1:0]   in_vertex_y,
  input  logic signed [pip_pkg::IN_W-1:0]   in_query_x,
  input  logic signed [pip_pkg::IN_W-1:0]   in_query_y,
  input  logic                              in_last_vertex,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_inside_res
);

  localparam int CW = COORD_BITS;
  localparam int PW = 2 * CW + 2;

  // polygon state
  logic signed [CW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                 have_first_r;
  logic                 parity_r;

  // stage 1: edge endpoints
  logic                 st1_v_r;
  logic signed [CW-1:0] s1_px_r, s1_py_r, s1_vx_r, s1_vy_r;
  logic signed [CW-1:0] s1_fx_r, s1_fy_r, s1_qx_r, s1_qy_r;
  logic                 s1_last_r, s1_new_r;

  // stage 2: flags and products
  logic                 st2_v_r;
  pip_pkg::edge_flags_t s2_fa_r, s2_fb_r;
  logic [PW-1:0]        s2_pa_a_r, s2_pa_b_r, s2_pb_a_r, s2_pb_b_r;
  logic                 s2_last_r, s2_new_r;

  // output register
  logic                 out_valid_r;
  logic                 out_inside_res_r;

  // handshake and datapath wires
  logic                 in_acc;
  logic                 out_free, st2_go, st2_free, st1_go, st1_free;
  logic signed [CW-1:0] vx, vy, qx, qy;
  logic signed [CW-1:0] first_x_nxt, first_y_nxt;
  pip_pkg::edge_flags_t fa, fb;
  logic [PW-1:0]        pa_a, pa_b, pb_a, pb_b;
  logic                 cross_a, cross_b, parity_nxt, res_nxt;

  // stage advance chain, bubbles collapse behind a waiting result
  assign out_free = !out_valid_r || out_ready;
  assign st2_go   = st2_v_r && (!s2_last_r || out_free);
  assign st2_free = !st2_v_r || st2_go;
  assign st1_go   = st1_v_r && st2_free;
  assign st1_free = !st1_v_r || st1_go;
  assign in_ready = st1_free;
  assign in_acc   = in_valid && in_ready;

  // coordinates narrowed to the working width
  assign vx = in_vertex_x[CW-1:0];
  assign vy = in_vertex_y[CW-1:0];
  assign qx = in_query_x[CW-1:0];
  assign qy = in_query_y[CW-1:0];

  // first vertex is latched by the opening word of a polygon
  assign first_x_nxt = have_first_r ? first_x_r : vx;
  assign first_y_nxt = have_first_r ? first_y_r : vy;

  // polygon state update on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      have_first_r <= 1'b0;
    end else if (in_acc) begin
      first_x_r    <= first_x_nxt;
      first_y_r    <= first_y_nxt;
      prev_x_r     <= vx;
      prev_y_r     <= vy;
      have_first_r <= !in_last_vertex;
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (st1_free) begin
      st1_v_r <= in_valid;
    end
  end

  // stage 1 payload: previous edge and closing edge endpoints
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= prev_x_r;
      s1_py_r   <= prev_y_r;
      s1_vx_r   <= vx;
      s1_vy_r   <= vy;
      s1_fx_r   <= first_x_nxt;
      s1_fy_r   <= first_y_nxt;
      s1_qx_r   <= qx;
      s1_qy_r   <= qy;
      s1_last_r <= in_last_vertex;
      s1_new_r  <= !have_first_r;
    end
  end

  // edge from previous vertex to this one
  pip_edge_cross #(.CW(CW)) u_edge_a (
    .sx     (s1_px_r),
    .sy     (s1_py_r),
    .ex     (s1_vx_r),
    .ey     (s1_vy_r),
    .qx     (s1_qx_r),
    .qy     (s1_qy_r),
    .flags  (fa),
    .prod_a (pa_a),
    .prod_b (pa_b)
  );

  // closing edge from this vertex back to the first
  pip_edge_cross #(.CW(CW)) u_edge_b (
    .sx     (s1_vx_r),
    .sy     (s1_vy_r),
    .ex     (s1_fx_r),
    .ey     (s1_fy_r),
    .qx     (s1_qx_r),
    .qy     (s1_qy_r),
    .flags  (fb),
    .prod_a (pb_a),
    .prod_b (pb_b)
  );

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_v_r <= 1'b0;
    end else if (st2_free) begin
      st2_v_r <= st1_v_r;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (st1_go) begin
      s2_fa_r   <= fa;
      s2_fb_r   <= fb;
      s2_pa_a_r <= pa_a;
      s2_pa_b_r <= pa_b;
      s2_pb_a_r <= pb_a;
      s2_pb_b_r <= pb_b;
      s2_last_r <= s1_last_r;
      s2_new_r  <= s1_new_r;
    end
  end

  // signed product compare (a <= b) with zero taken as non-negative
  function automatic logic prod_le(input logic na, input logic [PW-1:0] ma,
                                   input logic nb, input logic [PW-1:0] mb);
    logic sa;
    logic sb;
    sa = na && (ma != '0);
    sb = nb && (mb != '0);
    if (sa != sb) begin
      return sa;
    end else if (!sa) begin
      return ma <= mb;
    end else begin
      return ma >= mb;
    end
  endfunction

  // crossing decisions
  assign cross_a = s2_fa_r.horiz ? s2_fa_r.h_hit
                 : (s2_fa_r.in_band &&
                    prod_le(s2_fa_r.neg_a, s2_pa_a_r, s2_fa_r.neg_b, s2_pa_b_r));
  assign cross_b = s2_fb_r.horiz ? s2_fb_r.h_hit
                 : (s2_fb_r.in_band &&
                    prod_le(s2_fb_r.neg_a, s2_pb_a_r, s2_fb_r.neg_b, s2_pb_b_r));

  // parity loop: opening word has no incoming edge and restarts parity
  assign parity_nxt = s2_new_r ? 1'b0 : (parity_r ^ cross_a);
  assign res_nxt    = parity_nxt ^ cross_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
    end else if (st2_go) begin
      parity_r <= s2_last_r ? 1'b0 : parity_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st2_go && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st2_go && s2_last_r) begin
      out_inside_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;

  // a finished polygon always lands in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (st2_go && s2_last_r) |=> out_valid_r)
    else $error("last vertex left stage 2 without a result");

  // parity restarts after every polygon
  a_parity_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (st2_go && s2_last_r) |=> !parity_r)
    else $error("parity not cleared after a result");

  // a last vertex ends the polygon state
  a_polygon_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_vertex) |=> (!have_first_r && st1_v_r && s1_last_r))
    else $error("polygon state not closed on last vertex");

  // a stalled result never blocks an empty intake stage
  a_intake_open: assert property (@(posedge clk) disable iff (!rst_n)
    !st1_v_r |-> in_ready)
    else $error("input stalled with stage 1 empty");

endmodule

@@ hdl/pip_edge_cross.sv @@
// edge unit: differences, band test, signs and the two cross products of one edge
module pip_edge_cross #(
  parameter int CW = 32
) (
  input  logic signed [CW-1:0]  sx,
  input  logic signed [CW-1:0]  sy,
  input  logic signed [CW-1:0]  ex,
  input  logic signed [CW-1:0]  ey,
  input  logic signed [CW-1:0]  qx,
  input  logic signed [CW-1:0]  qy,
  output pip_pkg::edge_flags_t  flags,
  output logic [2*CW+1:0]       prod_a,
  output logic [2*CW+1:0]       prod_b
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dxe;
  logic signed [DW-1:0] dye;
  logic signed [DW-1:0] dyq;
  logic signed [DW-1:0] dxq;
  logic [DW-1:0]        mag_dxe;
  logic [DW-1:0]        mag_dye;
  logic [DW-1:0]        mag_dyq;
  logic [DW-1:0]        mag_dxq;
  logic                 rising;

  // differences, one bit wider so they never wrap
  assign dxe = $signed({ex[CW-1], ex}) - $signed({sx[CW-1], sx});
  assign dye = $signed({ey[CW-1], ey}) - $signed({sy[CW-1], sy});
  assign dyq = $signed({qy[CW-1], qy}) - $signed({sy[CW-1], sy});
  assign dxq = $signed({qx[CW-1], qx}) - $signed({sx[CW-1], sx});

  // magnitudes
  assign mag_dxe = dxe[DW-1] ? DW'(-dxe) : DW'(dxe);
  assign mag_dye = dye[DW-1] ? DW'(-dye) : DW'(dye);
  assign mag_dyq = dyq[DW-1] ? DW'(-dyq) : DW'(dyq);
  assign mag_dxq = dxq[DW-1] ? DW'(-dxq) : DW'(dxq);

  assign rising = !dye[DW-1];

  // band and horizontal-edge tests
  always_comb begin
    flags.horiz   = (dye == '0);
    flags.h_hit   = (dyq == '0) && (sx <= qx);
    if (rising) begin
      flags.in_band = !dyq[DW-1] && (dyq < dye);
    end else begin
      flags.in_band = (dyq[DW-1] || (dyq == '0)) && (dyq > dye);
    end
    flags.neg_a   = (dxe[DW-1] ^ dyq[DW-1]) ^ !rising;
    flags.neg_b   = dxq[DW-1];
  end

  // magnitude products of the division-free crossing test
  assign prod_a = PW'(mag_dxe) * PW'(mag_dyq);
  assign prod_b = PW'(mag_dxq) * PW'(mag_dye);

endmodule
